FILE: rtl/mme_pkg.sv
// Matrix multiply engine: shared constants, command codes and pipeline token type.
// No dependencies.
`default_nettype none

package mme_pkg;

    localparam int MAX_DIM_DEF    = 8;
    localparam int ELEM_WIDTH_DEF = 16;
    localparam int ACC_WIDTH_DEF  = 40;

    localparam int IDX_W  = 3;    // row / column / k index fields
    localparam int DIM_W  = 4;    // size registers
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B  = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE = 2'd2;

    localparam logic [1:0] REG_ROWS  = 2'd0;
    localparam logic [1:0] REG_INNER = 2'd1;
    localparam logic [1:0] REG_COLS  = 2'd2;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             lastk;
        logic [IDX_W-1:0] k;
    } mme_tok_t;

    // 0 is taken as 1, anything above the array size as the array size
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v, input int maxd);
        logic [DIM_W-1:0] r;
        begin
            if (v == '0)
                r = DIM_W'(1);
            else if (int'(v) > maxd)
                r = DIM_W'(maxd);
            else
                r = v;
            return r;
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mme_if.sv
// Matrix multiply engine: command and result channel interfaces.
// Depends on mme_pkg.
`default_nettype none

interface mme_cmd_if import mme_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic signed [15:0] element_value;

    modport source (output valid, output func, output row, output col,
                    output element_value, input ready);
    modport sink   (input valid, input func, input row, input col,
                    input element_value, output ready);
endinterface

interface mme_res_if import mme_pkg::*; #(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF
) ();
    logic                        valid;
    logic                        ready;
    logic [IDX_W-1:0]            out_row;
    logic [IDX_W-1:0]            out_col;
    logic signed [ACC_WIDTH-1:0] product_value;
    logic                        last;

    modport source (output valid, output out_row, output out_col,
                    output product_value, output last, input ready);
    modport sink   (input valid, input out_row, input out_col,
                    input product_value, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/mme_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/mme_mac_cell.sv
// One column cell: holds its column of B, multiplies the passing A element and
// accumulates. Depends on mme_pkg and mme_ram.
`default_nettype none

module mme_mac_cell import mme_pkg::*; #(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    parameter int ACC_WIDTH  = ACC_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   b_we,
    input  wire logic [IDX_W-1:0]       b_waddr,
    input  wire logic [ELEM_WIDTH-1:0]  b_wdata,
    input  wire mme_tok_t               tok_in,
    input  wire logic [ELEM_WIDTH-1:0]  a_in,
    output mme_tok_t                    tok_out,
    output logic      [ELEM_WIDTH-1:0]  a_out,
    output logic      [ACC_WIDTH-1:0]   acc,
    output logic                        done
);

    localparam int KAW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int PW  = 2 * ELEM_WIDTH;
    localparam int XW  = (PW > ACC_WIDTH) ? PW : ACC_WIDTH;

    logic [ELEM_WIDTH-1:0]  b_rdata;
    mme_tok_t               s1_reg;
    mme_tok_t               p_reg;
    logic [ELEM_WIDTH-1:0]  a_s1_reg;
    logic signed [PW-1:0]   prod_reg;
    logic signed [XW-1:0]   prod_ext;
    logic [ACC_WIDTH-1:0]   acc_reg;
    logic [ACC_WIDTH-1:0]   acc_next;
    logic                   done_reg;

    mme_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (MAX_DIM)
    ) u_b_col (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr[KAW-1:0]),
        .wdata (b_wdata),
        .raddr (tok_in.k[KAW-1:0]),
        .rdata (b_rdata)
    );

    assign prod_ext = XW'(prod_reg);
    assign acc_next = p_reg.first ? prod_ext[ACC_WIDTH-1:0]
                                  : acc_reg + prod_ext[ACC_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= '0;
            p_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= tok_in;
            p_reg    <= s1_reg;
            done_reg <= p_reg.valid & p_reg.lastk;
        end
    end

    always_ff @(posedge clk)
    begin
        a_s1_reg <= a_in;
        prod_reg <= signed'(a_s1_reg) * signed'(b_rdata);
        if (p_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign tok_out = s1_reg;
    assign a_out   = a_s1_reg;
    assign acc     = acc_reg;
    assign done    = done_reg;

endmodule

`default_nettype wire

FILE: rtl/matrix_multiply_engine.sv
// Matrix multiply engine top: size registers, A store, feeder, chain of column
// cells and result output register. Depends on mme_pkg, mme_if, mme_ram, mme_mac_cell.
// Load transfers are taken only while idle. A compute feeds, per row of C,
// inner_used k steps, drains the chain until its last cell is done, then emits
// cols_used results (held while the sink stalls); no new command is taken meanwhile.
// Reset: size registers return to 8, control clears; stores stay undefined.
`default_nettype none

module matrix_multiply_engine import mme_pkg::*; #(
    parameter int MAX_DIM    = MAX_DIM_DEF,
    parameter int ELEM_WIDTH = ELEM_WIDTH_DEF,
    parameter int ACC_WIDTH  = ACC_WIDTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    mme_cmd_if.sink                  cmd,
    mme_res_if.source                res,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [PADDR_W-1:0]  paddr,
    input  wire logic [PDATA_W-1:0]  pwdata,
    output logic      [PDATA_W-1:0]  prdata,
    output logic                     pready
);

    localparam int AAW = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;
    localparam int KAW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FEED  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [DIM_W-1:0] rows_reg, inner_reg, cols_reg;
    logic [DIM_W-1:0] nr, nk, nc;
    logic             cfg_wr;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] j_reg, j_next;
    mme_tok_t         feed_reg, feed_next;

    logic                   cmd_fire;
    logic                   load_a, load_b;
    logic [ELEM_WIDTH-1:0]  elem;
    logic [ELEM_WIDTH-1:0]  a_rdata;
    logic [AAW-1:0]         a_waddr, a_raddr;
    logic [MAX_DIM-1:0]     b_we;

    mme_tok_t               tok   [MAX_DIM+1];
    logic [ELEM_WIDTH-1:0]  a_tok [MAX_DIM+1];
    logic [ACC_WIDTH-1:0]   acc_col [MAX_DIM];
    logic [MAX_DIM-1:0]     done;

    logic                   emit_load;
    logic                   out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]       out_row_reg, out_col_reg;
    logic [ACC_WIDTH-1:0]   out_val_reg;
    logic                   out_last_reg;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= DIM_W'(8);
            inner_reg <= DIM_W'(8);
            cols_reg  <= DIM_W'(8);
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_ROWS:  rows_reg  <= pwdata[DIM_W-1:0];
                REG_INNER: inner_reg <= pwdata[DIM_W-1:0];
                REG_COLS:  cols_reg  <= pwdata[DIM_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ROWS:  prdata = PDATA_W'(rows_reg);
            REG_INNER: prdata = PDATA_W'(inner_reg);
            REG_COLS:  prdata = PDATA_W'(cols_reg);
            default:   prdata = '0;
        endcase
    end

    assign nr = eff_dim(rows_reg, MAX_DIM);
    assign nk = eff_dim(inner_reg, MAX_DIM);
    assign nc = eff_dim(cols_reg, MAX_DIM);

    // load decode
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid & cmd.ready;
    assign elem      = ELEM_WIDTH'(cmd.element_value);

    always_comb
    begin
        load_a = 1'b0;
        load_b = 1'b0;
        case (cmd.func)
            FUNC_LOAD_A: load_a = cmd_fire && ({1'b0, cmd.row} < nr) && ({1'b0, cmd.col} < nk);
            FUNC_LOAD_B: load_b = cmd_fire && ({1'b0, cmd.row} < nk) && ({1'b0, cmd.col} < nc);
            default:     ;
        endcase
    end

    assign a_waddr = AAW'(int'(cmd.row) * MAX_DIM + int'(cmd.col));
    assign a_raddr = AAW'(int'(i_reg) * MAX_DIM + int'(k_reg));

    mme_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (MAX_DIM * MAX_DIM)
    ) u_a_store (
        .clk   (clk),
        .we    (load_a),
        .waddr (a_waddr),
        .wdata (elem),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    // cell chain
    assign tok[0]   = feed_reg;
    assign a_tok[0] = a_rdata;

    for (genvar c = 0; c < MAX_DIM; c++)
    begin : g_cell
        assign b_we[c] = load_b && (cmd.col[KAW-1:0] == KAW'(c));

        mme_mac_cell #(
            .MAX_DIM    (MAX_DIM),
            .ELEM_WIDTH (ELEM_WIDTH),
            .ACC_WIDTH  (ACC_WIDTH)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .b_we    (b_we[c]),
            .b_waddr (cmd.row),
            .b_wdata (elem),
            .tok_in  (tok[c]),
            .a_in    (a_tok[c]),
            .tok_out (tok[c+1]),
            .a_out   (a_tok[c+1]),
            .acc     (acc_col[c]),
            .done    (done[c])
        );
    end

    // sequencer
    assign emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || res.ready);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        j_next     = j_reg;
        feed_next  = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && cmd.func == FUNC_COMPUTE)
                begin
                    i_next     = '0;
                    k_next     = '0;
                    state_next = ST_FEED;
                end
            end
            ST_FEED:
            begin
                feed_next.valid = 1'b1;
                feed_next.first = (k_reg == '0);
                feed_next.lastk = ({1'b0, k_reg} == nk - 1'b1);
                feed_next.k     = k_reg;
                k_next          = k_reg + 1'b1;
                if ({1'b0, k_reg} == nk - 1'b1)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (done[MAX_DIM-1])
                begin
                    j_next     = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    j_next = j_reg + 1'b1;
                    if ({1'b0, j_reg} == nc - 1'b1)
                    begin
                        if ({1'b0, i_reg} == nr - 1'b1)
                            state_next = ST_IDLE;
                        else
                        begin
                            i_next     = i_reg + 1'b1;
                            k_next     = '0;
                            state_next = ST_FEED;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid_next = emit_load | (out_valid_reg & ~res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            feed_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            feed_reg      <= feed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_row_reg  <= i_reg;
            out_col_reg  <= j_reg;
            out_val_reg  <= acc_col[j_reg[KAW-1:0]];
            out_last_reg <= ({1'b0, i_reg} == nr - 1'b1) && ({1'b0, j_reg} == nc - 1'b1);
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.out_row       = out_row_reg;
    assign res.out_col       = out_col_reg;
    assign res.product_value = out_val_reg;
    assign res.last          = out_last_reg;

endmodule

`default_nettype wire
